>>> design/pbu_pkg.sv
// Shared constants, codes and the sequencer state type of the belief update block.
`timescale 1ns / 1ps
package pbu_pkg;

  // Probability format: unsigned Q1.15, one is 1 << 15
  localparam int PROB_FRAC_BITS = 15;
  localparam int PROB_W         = PROB_FRAC_BITS + 1;
  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;
  localparam int MAX_OUT        = 16;

  // Parameter defaults
  localparam int NUM_STATES_DEF       = 16;
  localparam int NUM_ACTIONS_DEF      = 4;
  localparam int NUM_OBSERVATIONS_DEF = 4;

  // Field widths fixed by the item format
  localparam int OP_W    = 2;
  localparam int ACT_W   = 2;
  localparam int STATE_W = 4;
  localparam int OBS_W   = 2;
  localparam int CFG_W   = 5;
  localparam logic [CFG_W-1:0] STATES_IN_USE_RST = 5'd16;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD_TRANS  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_OBS    = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_BELIEF = 2'd2;
  localparam logic [OP_W-1:0] OP_UPDATE      = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_PRED,
    ST_UNORM,
    ST_ACCU,
    ST_FIN,
    ST_RD,
    ST_DIVST,
    ST_DIVW,
    ST_EMIT
  } pbu_state_t;

  // Divider handshake toward the sequencer
  typedef struct packed {
    logic                done;
    logic [PROB_W-1:0]   quot;
  } pbu_div_rsp_t;

endpackage

>>> design/pbu_div.sv
// Bit-serial restoring divider giving num / den in Q1.15, rounded half up, saturated at one.
`timescale 1ns / 1ps
module pbu_div import pbu_pkg::*; #(
  parameter int DW = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output pbu_div_rsp_t  rsp
);

  localparam int CW = $clog2(PROB_FRAC_BITS + 1);

  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     den_r;
  logic [PROB_W-1:0] quot_r, quot_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DW:0]       twice;
  logic              ge;

  assign twice = {rem_r, 1'b0};
  assign ge    = (twice >= {1'b0, den_r});

  // One quotient bit per cycle, then the rounding step
  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      if (num >= den) begin
        quot_nxt = PROB_ONE;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = num;
        quot_nxt = '0;
        cnt_nxt  = CW'(PROB_FRAC_BITS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        quot_nxt = {quot_r[PROB_W-2:0], ge};
        rem_nxt  = ge ? DW'(twice - {1'b0, den_r}) : DW'(twice);
        cnt_nxt  = cnt_r - CW'(1);
      end else begin
        quot_nxt = quot_r + PROB_W'(ge);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    if (start) den_r <= den;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

>>> design/pomdp_belief_update.sv
// Top level of the discrete Bayes filter belief update: tables, sequencer and shared multiplier.
// An update of n active states runs, per state, the prediction loop (one multiply-accumulate
// per cycle on the transition table read port, then drain, round, observation product and
// likelihood add), then finishes the likelihood, then per state runs the serial divider plus
// output handshake (the divider skips its bit loop when the quotient saturates, and no divide
// runs when the likelihood is zero); the output handshake may stall. in_tready is low for the
// whole update. Reset (rst_n, synchronous) clears the sequencer and sets states_in_use to 16;
// table and belief memories are not cleared.
`timescale 1ns / 1ps
module pomdp_belief_update import pbu_pkg::*; #(
  parameter int NUM_STATES       = NUM_STATES_DEF,
  parameter int NUM_ACTIONS      = NUM_ACTIONS_DEF,
  parameter int NUM_OBSERVATIONS = NUM_OBSERVATIONS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: action[1:0], from_state[5:2], to_state[9:6], observation[11:10],
  //           probability[27:12], zero pad
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,
  input  logic [OP_W-1:0]  in_tuser,   // opcode
  // out_tdata: state_index[3:0], belief_value[19:4], obs_likelihood[35:20], zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,
  output logic             out_tuser,  // zero_likelihood
  output logic             out_tlast,  // last_entry
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata   // states_in_use
);

  localparam int SW    = $clog2(NUM_STATES);
  localparam int TD    = NUM_STATES * NUM_ACTIONS * NUM_STATES;
  localparam int OD    = NUM_ACTIONS * NUM_STATES * NUM_OBSERVATIONS;
  localparam int TAW   = $clog2(TD);
  localparam int OAW   = (OD > 1) ? $clog2(OD) : 1;
  localparam int PW    = PROB_W;
  localparam int MW    = 2 * PW;
  localparam int AW    = MW + SW;
  localparam int NLIM  = (NUM_STATES < MAX_OUT) ? NUM_STATES : MAX_OUT;

  // Rounding of a wide Q6.30 sum to Q1.15, half up, saturated
  function automatic logic [PW-1:0] round_prob(input logic [AW-1:0] x);
    logic [AW:0] sum;
    logic [AW:0] sh;
    sum = {1'b0, x} + (AW+1)'(1 << (PROB_FRAC_BITS - 1));
    sh  = sum >> PROB_FRAC_BITS;
    if (sh > (AW+1)'(PROB_ONE)) return PROB_ONE;
    else return PW'(sh);
  endfunction

  // Input field split
  logic [ACT_W-1:0]   f_act;
  logic [STATE_W-1:0] f_from, f_to;
  logic [OBS_W-1:0]   f_obs;
  logic [PW-1:0]      f_prob_raw, f_prob;
  assign f_act      = in_tdata[1:0];
  assign f_from     = in_tdata[5:2];
  assign f_to       = in_tdata[9:6];
  assign f_obs      = in_tdata[11:10];
  assign f_prob_raw = in_tdata[27:12];
  assign f_prob     = (f_prob_raw > PROB_ONE) ? PROB_ONE : f_prob_raw;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  logic act_ok, from_ok, to_ok, obs_ok;
  assign act_ok  = (int'(f_act) < NUM_ACTIONS);
  assign from_ok = (int'(f_from) < NUM_STATES);
  assign to_ok   = (int'(f_to) < NUM_STATES);
  assign obs_ok  = (int'(f_obs) < NUM_OBSERVATIONS);

  // Configuration register
  logic [CFG_W-1:0] cfg_n_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_n_r <= STATES_IN_USE_RST;
    else if (cfg_we) cfg_n_r <= cfg_wdata;
  end

  logic [CFG_W-1:0] n_eff;
  always_comb begin
    if (cfg_n_r == '0) n_eff = CFG_W'(1);
    else if (int'(cfg_n_r) > NLIM) n_eff = CFG_W'(NLIM);
    else n_eff = cfg_n_r;
  end

  // Sequencer registers
  pbu_state_t       state_r, state_nxt;
  logic [SW-1:0]    s_r, s_nxt, k_r, k_nxt;
  logic [CFG_W-1:0] n_r;
  logic [ACT_W-1:0] a_r;
  logic [OBS_W-1:0] o_r;

  logic last_k, last_s;
  assign last_k = (int'(k_r) + 1 == int'(n_r));
  assign last_s = (int'(s_r) + 1 == int'(n_r));

  // Datapath registers
  logic          p1_v_r, p1_last_r, p2_v_r, p2_last_r;
  logic [MW-1:0] prod_r;
  logic [AW-1:0] acc_r, lik_r;
  logic [PW-1:0] pred_r, likq_r;
  logic          zero_r;
  logic [PW-1:0] out_bel_r;

  // Memories and read data
  logic [PW-1:0] trans_mem [TD];
  logic [PW-1:0] obs_mem   [OD];
  logic [PW-1:0] bel_mem   [NUM_STATES];
  logic [MW-1:0] unorm_mem [NUM_STATES];
  logic [PW-1:0] trans_q_r, obs_q_r, bel_q_r;
  logic [MW-1:0] unorm_q_r;

  pbu_div_rsp_t div_rsp;

  // Strobes from the sequencer
  logic start_upd, issue, acc_clr, do_pred, do_unorm, do_accu, do_fin;
  logic div_start, cap_zero, cap_div;

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    k_nxt     = k_r;
    start_upd = 1'b0;
    issue     = 1'b0;
    acc_clr   = 1'b0;
    do_pred   = 1'b0;
    do_unorm  = 1'b0;
    do_accu   = 1'b0;
    do_fin    = 1'b0;
    div_start = 1'b0;
    cap_zero  = 1'b0;
    cap_div   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_tuser == OP_UPDATE && act_ok && obs_ok) begin
          start_upd = 1'b1;
          acc_clr   = 1'b1;
          s_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (last_k) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + SW'(1);
        end
      end
      ST_DRAIN: begin
        if (p2_v_r && p2_last_r) state_nxt = ST_PRED;
      end
      ST_PRED: begin
        do_pred   = 1'b1;
        state_nxt = ST_UNORM;
      end
      ST_UNORM: begin
        do_unorm  = 1'b1;
        state_nxt = ST_ACCU;
      end
      ST_ACCU: begin
        do_accu = 1'b1;
        if (last_s) begin
          state_nxt = ST_FIN;
        end else begin
          s_nxt     = s_r + SW'(1);
          acc_clr   = 1'b1;
          state_nxt = ST_MAC;
        end
      end
      ST_FIN: begin
        do_fin    = 1'b1;
        s_nxt     = '0;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_DIVST;
      end
      ST_DIVST: begin
        if (zero_r) begin
          cap_zero  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_rsp.done) begin
          cap_div   = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          if (last_s) begin
            state_nxt = ST_IDLE;
          end else begin
            s_nxt     = s_r + SW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      s_r       <= '0;
      k_r       <= '0;
      p1_v_r    <= 1'b0;
      p1_last_r <= 1'b0;
      p2_v_r    <= 1'b0;
      p2_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      s_r       <= s_nxt;
      k_r       <= k_nxt;
      p1_v_r    <= issue;
      p1_last_r <= issue && last_k;
      p2_v_r    <= p1_v_r;
      p2_last_r <= p1_v_r && p1_last_r;
    end
  end

  // Shared multiplier: transition x belief in the loop, prediction x observation after it
  logic [PW-1:0] mul_a, mul_b;
  assign mul_a = do_unorm ? pred_r  : trans_q_r;
  assign mul_b = do_unorm ? obs_q_r : bel_q_r;

  // Datapath
  always_ff @(posedge clk) begin
    if (start_upd) begin
      n_r <= n_eff;
      a_r <= f_act;
      o_r <= f_obs;
    end
    if (p1_v_r || do_unorm) prod_r <= mul_a * mul_b;
    if (acc_clr) acc_r <= '0;
    else if (p2_v_r) acc_r <= acc_r + AW'(prod_r);
    if (do_pred) pred_r <= round_prob(acc_r);
    if (start_upd) lik_r <= '0;
    else if (do_accu) lik_r <= lik_r + AW'(prod_r);
    if (do_fin) begin
      zero_r <= (lik_r == '0);
      likq_r <= (lik_r == '0) ? '0 : round_prob(lik_r);
    end
    if (cap_zero) out_bel_r <= bel_q_r;
    else if (cap_div) out_bel_r <= div_rsp.quot;
  end

  // Memory addresses
  logic [TAW-1:0] trans_wa, trans_ra;
  logic [OAW-1:0] obs_wa, obs_ra;
  logic [SW-1:0]  bel_wa, bel_ra;
  logic           trans_we, obs_we, bel_we;
  logic [PW-1:0]  bel_wd;

  assign trans_wa = TAW'((int'(f_from) * NUM_ACTIONS + int'(f_act)) * NUM_STATES + int'(f_to));
  assign trans_ra = TAW'((int'(k_r) * NUM_ACTIONS + int'(a_r)) * NUM_STATES + int'(s_r));
  assign obs_wa   = OAW'((int'(f_act) * NUM_STATES + int'(f_to)) * NUM_OBSERVATIONS
                         + int'(f_obs));
  assign obs_ra   = OAW'((int'(a_r) * NUM_STATES + int'(s_r)) * NUM_OBSERVATIONS + int'(o_r));

  assign trans_we = in_xfer && in_tuser == OP_LOAD_TRANS && from_ok && act_ok && to_ok;
  assign obs_we   = in_xfer && in_tuser == OP_LOAD_OBS && act_ok && to_ok && obs_ok;
  assign bel_we   = (in_xfer && in_tuser == OP_LOAD_BELIEF && to_ok) || cap_div;
  assign bel_wa   = cap_div ? s_r : SW'(f_to);
  assign bel_wd   = cap_div ? div_rsp.quot : f_prob;
  assign bel_ra   = (state_r == ST_MAC) ? k_r : s_r;

  // Table and belief memories, registered read
  always_ff @(posedge clk) begin
    if (trans_we) trans_mem[trans_wa] <= f_prob;
    trans_q_r <= trans_mem[trans_ra];
  end

  always_ff @(posedge clk) begin
    if (obs_we) obs_mem[obs_wa] <= f_prob;
    obs_q_r <= obs_mem[obs_ra];
  end

  always_ff @(posedge clk) begin
    if (bel_we) bel_mem[bel_wa] <= bel_wd;
    bel_q_r <= bel_mem[bel_ra];
  end

  always_ff @(posedge clk) begin
    if (do_accu) unorm_mem[s_r] <= prod_r;
    unorm_q_r <= unorm_mem[s_r];
  end

  pbu_div #(
    .DW (AW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (AW'(unorm_q_r)),
    .den   (lik_r),
    .rsp   (div_rsp)
  );

  // Handshake and result
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {4'd0, likq_r, out_bel_r, STATE_W'(s_r)};
  assign out_tuser  = zero_r;
  assign out_tlast  = last_s;

endmodule
